FILE: sv/sliding_window_median_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window median filter
// Concurrent check wrappers that compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define SWMF_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Checks that a consequent follows from an antecedent in the same cycle.
`define SWMF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent follows in the cycle after an antecedent.
`define SWMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define SWMF_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define SWMF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define SWMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/swmf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median filter package
// Sizes, shared types and the window size clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

    localparam int WINDOW_MAX  = 9;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 4;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] WIN_SIZE_RST = CFG_W'(3);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [WINDOW_MAX-1:0]  t_mask;
    typedef t_sample                t_win [WINDOW_MAX];

    // Ranking controls shared by every cell of the chain.
    typedef struct packed {
        t_mask act;
        t_cnt  rank;
    } t_rank_ctl;

    // A window size of zero acts as one; sizes past the storage saturate.
    function automatic t_cnt eff_size(input logic [CFG_W-1:0] ws);
        t_cnt k;
        if (ws == '0) begin
            k = CNT_W'(1);
        end else if (int'(ws) > WINDOW_MAX) begin
            k = CNT_W'(WINDOW_MAX);
        end else begin
            k = CNT_W'(ws);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: sv/sliding_window_median_filter_core.sv
// ----------------------------------------------------------------------------
// Sliding window median filter core
// An input transfer shifts into the cell row and its median goes to the output register.
// One sample is taken per cycle unless the output stalls; ranking runs in parallel over the cell row.
// Reset clears the fill count, the valid flags and sets window_size to 3.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_median_filter_core_defines.svh"

module sliding_window_median_filter_core
    import swmf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration: window_size.
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    // Input stream.
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [TDATA_W-1:0] i_s_tdata,  // [15:0] sample
    input  wire logic               i_s_tuser,  // [0] start_req
    // Output stream.
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [TDATA_W-1:0]      o_m_tdata   // [15:0] median
);

    logic [CFG_W-1:0] r_win_size;
    t_cnt             r_fill;
    t_cnt             n_fill;
    t_cnt             k_eff;

    logic    r_a_vld;
    logic    r_a_emit;
    t_cnt    r_a_k;

    logic    r_out_vld;
    t_sample r_median;
    t_sample median_sel;

    logic      s_acc;
    logic      a_go;
    t_rank_ctl ctl;
    t_win      win;
    t_mask     hit;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign a_go       = r_a_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_a_vld || a_go;
    assign k_eff      = eff_size(r_win_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= WIN_SIZE_RST;
        end else if (i_cfg_we) begin
            r_win_size <= i_cfg_wdata;
        end
    end

    // Fill count saturates at the storage depth; a start flag restarts it.
    always_comb begin
        if (i_s_tuser) begin
            n_fill = CNT_W'(1);
        end else if (r_fill < CNT_W'(WINDOW_MAX)) begin
            n_fill = r_fill + CNT_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_a_vld <= 1'b0;
        end else if (s_acc) begin
            r_fill  <= n_fill;
            r_a_vld <= 1'b1;
        end else if (a_go) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a_emit <= (n_fill >= k_eff);
            r_a_k    <= k_eff;
        end
    end

    always_comb begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            ctl.act[j] = (CNT_W'(j) < r_a_k);
        end
        ctl.rank = r_a_k >> 1;
    end

    // The cells only shift on an input transfer, so the window stays put
    // while the ranked item waits for the output register.
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_sample cell_in;
        if (g == 0) begin : g_head
            assign cell_in = i_s_tdata[SAMPLE_BITS-1:0];
        end else begin : g_link
            assign cell_in = win[g-1];
        end
        swmf_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (s_acc),
            .i_sample (cell_in),
            .i_win    (win),
            .i_ctl    (ctl),
            .i_act    (ctl.act[g]),
            .o_hit    (hit[g]),
            .o_sample (win[g])
        );
    end

    // Equal samples may all hit; they carry the same value, so OR them.
    always_comb begin
        median_sel = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            if (hit[j]) begin
                median_sel = median_sel | win[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (a_go) begin
            r_out_vld <= r_a_emit;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_median <= median_sel;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = TDATA_W'(r_median);

    `SWMF_ASSERT_ALWAYS(a_fill_range, i_clk, i_rst_n, r_fill <= CNT_W'(WINDOW_MAX), "fill count past window depth")
    `SWMF_ASSERT_NEXT(a_start_fill, i_clk, i_rst_n, s_acc && i_s_tuser, r_fill == CNT_W'(1), "start did not restart fill count")
    `SWMF_ASSERT_SAME(a_stall_hold, i_clk, i_rst_n, r_a_vld && r_out_vld && !i_m_tready, !o_s_tready, "input taken while ranked item is blocked")
    `SWMF_ASSERT_SAME(a_out_source, i_clk, i_rst_n, $rose(o_m_tvalid), $past(r_a_vld && r_a_emit), "result without a full window")

endmodule

`default_nettype wire

FILE: sv/swmf_cell.sv
// ----------------------------------------------------------------------------
// Median filter window cell
// Holds one sample of the window, passes it to the next cell on each shift
// and reports whether its sample sits at the requested sorted rank.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_cell
    import swmf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_shift,
    input  wire t_sample   i_sample,
    input  wire t_win      i_win,
    input  wire t_rank_ctl i_ctl,
    input  wire logic      i_act,
    output logic           o_hit,
    output t_sample        o_sample
);

    t_sample r_sample;
    t_cnt    less;
    t_cnt    leq;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    // Count the active window entries below and not above this sample.
    always_comb begin
        less = '0;
        leq  = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            if (i_ctl.act[j] && (i_win[j] < r_sample)) begin
                less = less + CNT_W'(1);
            end
            if (i_ctl.act[j] && (i_win[j] <= r_sample)) begin
                leq = leq + CNT_W'(1);
            end
        end
    end

    assign o_hit    = i_act && (less <= i_ctl.rank) && (i_ctl.rank < leq);
    assign o_sample = r_sample;

endmodule

`default_nettype wire

FILE: test/tb_sliding_window_median_filter_core.sv
// ----------------------------------------------------------------------------
// Testbench for the sliding window median filter core
// Streams sample sequences through the core under several window sizes and
// flow-control mixes, and checks each median against a local window model.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_filter_core;
    import swmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int SEG_ITEMS    = 70;
    localparam int SEGS_PER_MIX = 6;
    localparam int DRAIN_CYCLES = 4;

    // Keeps a copy of the sample history and the fill count, and queues the
    // median that each sample transfer should produce.
    class median_scoreboard;
        t_sample          history [WINDOW_MAX];
        int               fill;
        logic [CFG_W-1:0] win_reg;
        t_sample          median_q [$];
        int               errors;
        int               samples_seen;
        int               medians_seen;

        function new();
            fill    = 0;
            win_reg = WIN_SIZE_RST;
            errors  = 0;
            samples_seen = 0;
            medians_seen = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] value);
            win_reg = value;
        endfunction

        function int pending();
            return median_q.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] MISMATCH %s", $realtime, msg);
            end
        endfunction

        function void note_sample(t_sample s, bit start_req);
            t_sample sorted [WINDOW_MAX];
            t_sample tmp;
            int      k;
            int      j;
            samples_seen++;
            if (start_req) begin
                fill = 0;
            end
            for (int i = WINDOW_MAX - 1; i > 0; i--) begin
                history[i] = history[i-1];
            end
            history[0] = s;
            if (fill < WINDOW_MAX) begin
                fill++;
            end
            // Zero acts as one and sizes past the storage saturate.
            k = (win_reg == 0) ? 1 : ((int'(win_reg) > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg));
            if (fill < k) begin
                return;
            end
            for (int i = 0; i < k; i++) begin
                tmp = history[i];
                j = i;
                while (j > 0 && sorted[j-1] > tmp) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = tmp;
            end
            median_q.push_back(sorted[k/2]);
        endfunction

        function void check_median(t_sample got);
            t_sample want;
            medians_seen++;
            if (median_q.size() == 0) begin
                report($sformatf("median %h arrived with none expected", got));
                return;
            end
            want = median_q.pop_front();
            if (got !== want) begin
                report($sformatf("median expected %h actual %h", want, got));
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // [15:0] sample
    logic               s_tuser;   // [0] start_req
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // [15:0] median

    median_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int seq_left;

    sliding_window_median_filter_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Input transfers are noted before output transfers of the same edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser);
            end
            if (m_tvalid && m_tready) begin
                sb.check_median(m_tdata[SAMPLE_BITS-1:0]);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_sample(input t_sample s, input bit start_req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = TDATA_W'(s);
        s_tuser  = start_req;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Holds the sender off until every expected median has come out.
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_window(value);
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return t_sample'($urandom_range(7));
            5:       return t_sample'($urandom_range(65535, 65528));
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Mostly long sequences that reach a full window; a few short ones are
    // cut off by the next start, too early for a median at the larger sizes.
    task automatic send_random_sample();
        bit start_req;
        start_req = 1'b0;
        if (seq_left == 0) begin
            start_req = 1'b1;
            seq_left  = ($urandom_range(9) == 0) ? $urandom_range(4, 1) : $urandom_range(40, 5);
        end
        seq_left--;
        send_sample(pick_sample(), start_req);
    endtask

    initial begin
        logic [CFG_W-1:0] windows [16] = '{3, 5, 7, 9, 1, 2, 4, 6, 8, 0, 15, 10, 11, 12, 13, 14};
        int               mix_send [3] = '{27, 59, 0};
        int               mix_recv [3] = '{59, 27, 0};

        sb = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles  = 0;
        seq_left      = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset window of three: extremes, ties, fill past the storage depth,
        // then a restart that leaves too few samples for a median.
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFE, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h4321, 1'b0);
        drain();
        // A zero window acts as a window of one and applies mid-sequence.
        write_window(4'd0);
        send_sample(16'hC3C3, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        drain();
        // An oversized window saturates at the storage depth.
        write_window(4'd15);
        for (int i = 0; i < 9; i++) begin
            send_sample(t_sample'(16'hF00F ^ (i * 16'h1111)), 1'b0);
        end

        for (int mix = 0; mix < 3; mix++) begin
            send_idle_pct = mix_send[mix];
            recv_idle_pct = mix_recv[mix];
            for (int seg = 0; seg < SEGS_PER_MIX; seg++) begin
                drain();
                write_window(windows[(mix * SEGS_PER_MIX + seg) % 16]);
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    send_random_sample();
                end
            end
        end

        drain();
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d medians never arrived", sb.pending()));
        end
        $display("Run covered %0d samples and %0d medians over all 16 window settings,",
                 sb.samples_seen, sb.medians_seen);
        $display("with sender and receiver stalls in both directions and at full rate.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
